// ----- hw/rtl/obl_pkg.sv -----
// ----------------------------------------------------------------------------
// obl_pkg
// Shared types and constants of the sorted price level table.
// ----------------------------------------------------------------------------
package obl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int CW          = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_MODIFY = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;

  typedef enum logic [3:0] {
    ST_INSERTED = 4'd0,
    ST_MODIFIED = 4'd1,
    ST_DELETED  = 4'd2,
    ST_NOTFOUND = 4'd3,
    ST_FULL     = 4'd4,
    ST_IGNORED  = 4'd5,
    ST_UNKNOWN  = 4'd6,
    ST_READOK   = 4'd7,
    ST_RANKOUT  = 4'd8
  } status_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_SRCH_INIT, CMD_RD_MID, CMD_CMP_MID, CMD_RD_SLOT,
    CMD_RD_RANK, CMD_MOD_WR, CMD_INS_INIT, CMD_INS_RD, CMD_INS_WR, CMD_WR_NEW,
    CMD_DEL_INIT, CMD_DEL_RD, CMD_DEL_WR, CMD_DEL_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    result;
    status_t code;
  } obl_cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       amt_pos;
    logic       rank_ok;
    logic       srch_done;
    logic       hit;
    logic       full;
    logic       ins_done;
    logic       del_done;
    logic       out_free;
  } obl_sts_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SRCH, S_SRCH_CMP, S_HIT_CHK, S_INS_LOOP, S_INS_WR,
    S_DEL_LOOP, S_DEL_WR, S_RD_WAIT, S_RESULT
  } state_t;

  typedef struct packed {
    logic [15:0] key;
    logic [31:0] price;
    logic [31:0] amount;
  } entry_t;

endpackage

// ----- hw/rtl/obl_ctrl.sv -----
// ----------------------------------------------------------------------------
// obl_ctrl
// Sequencer for search, shift, update and result steps of the level table.
// ----------------------------------------------------------------------------
module obl_ctrl import obl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  obl_sts_t sts,
  output obl_cmd_t cmd
);

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    code_r <= code_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    code_nxt   = code_r;
    cmd.op     = CMD_NONE;
    cmd.result = 1'b0;
    cmd.code   = code_r;
    in_tready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = CMD_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.opcode)
          OP_INSERT, OP_MODIFY: begin
            if (sts.amt_pos) begin
              cmd.op    = CMD_SRCH_INIT;
              state_nxt = S_SRCH;
            end else begin
              code_nxt  = ST_IGNORED;
              state_nxt = S_RESULT;
            end
          end
          OP_DELETE: begin
            cmd.op    = CMD_SRCH_INIT;
            state_nxt = S_SRCH;
          end
          OP_READ: begin
            if (sts.rank_ok) begin
              cmd.op    = CMD_RD_RANK;
              state_nxt = S_RD_WAIT;
            end else begin
              code_nxt  = ST_RANKOUT;
              state_nxt = S_RESULT;
            end
          end
          default: begin
            code_nxt  = ST_UNKNOWN;
            state_nxt = S_RESULT;
          end
        endcase
      end
      S_SRCH: begin
        if (sts.srch_done) begin
          cmd.op    = CMD_RD_SLOT;
          state_nxt = S_HIT_CHK;
        end else begin
          cmd.op    = CMD_RD_MID;
          state_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd.op    = CMD_CMP_MID;
        state_nxt = S_SRCH;
      end
      S_HIT_CHK: begin
        if (sts.opcode == OP_DELETE) begin
          if (sts.hit) begin
            cmd.op    = CMD_DEL_INIT;
            state_nxt = S_DEL_LOOP;
          end else begin
            code_nxt  = ST_NOTFOUND;
            state_nxt = S_RESULT;
          end
        end else if (sts.hit) begin
          cmd.op    = CMD_MOD_WR;
          code_nxt  = ST_MODIFIED;
          state_nxt = S_RESULT;
        end else if (sts.full) begin
          code_nxt  = ST_FULL;
          state_nxt = S_RESULT;
        end else begin
          cmd.op    = CMD_INS_INIT;
          state_nxt = S_INS_LOOP;
        end
      end
      S_INS_LOOP: begin
        if (sts.ins_done) begin
          cmd.op    = CMD_WR_NEW;
          code_nxt  = ST_INSERTED;
          state_nxt = S_RESULT;
        end else begin
          cmd.op    = CMD_INS_RD;
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.op    = CMD_INS_WR;
        state_nxt = S_INS_LOOP;
      end
      S_DEL_LOOP: begin
        if (sts.del_done) begin
          cmd.op    = CMD_DEL_DONE;
          code_nxt  = ST_DELETED;
          state_nxt = S_RESULT;
        end else begin
          cmd.op    = CMD_DEL_RD;
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.op    = CMD_DEL_WR;
        state_nxt = S_DEL_LOOP;
      end
      S_RD_WAIT: begin
        code_nxt  = ST_READOK;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.result = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/obl_dp.sv -----
// ----------------------------------------------------------------------------
// obl_dp
// Entry memory, binary search registers, shift index and result register.
// ----------------------------------------------------------------------------
module obl_dp import obl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [2:0]   in_opcode,
  input  logic [15:0]  in_key,
  input  logic [31:0]  in_price,
  input  logic [31:0]  in_amount,
  input  logic [9:0]   in_rank,
  input  obl_cmd_t     cmd,
  output obl_sts_t     sts,
  output logic         out_valid,
  input  logic         out_ready,
  output status_t      out_status,
  output entry_t       out_entry,
  output logic [10:0]  out_count
);

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_r;

  logic [2:0]    op_r;
  logic [15:0]   key_r;
  logic [31:0]   price_r, amount_r;
  logic [9:0]    rank_r;
  logic [CW-1:0] count_r, lo_r, hi_r, mid_r, idx_r;
  logic          out_valid_r;
  status_t       out_status_r;
  entry_t        out_entry_r;
  logic [10:0]   out_count_r;

  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_w;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_w   = mid_sum[CW:1];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid_w[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_r[AW-1:0];
    wr_data = rdata_r;
    case (cmd.op)
      CMD_RD_MID:  rd_en = 1'b1;
      CMD_RD_SLOT: begin
        rd_en   = 1'b1;
        rd_addr = lo_r[AW-1:0];
      end
      CMD_RD_RANK: begin
        rd_en   = 1'b1;
        rd_addr = AW'(rank_r);
      end
      CMD_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx_r - 1'b1);
      end
      CMD_DEL_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx_r + 1'b1);
      end
      CMD_INS_WR, CMD_DEL_WR: wr_en = 1'b1;
      CMD_MOD_WR, CMD_WR_NEW: begin
        wr_en   = 1'b1;
        wr_addr = lo_r[AW-1:0];
        wr_data = '{key: key_r, price: price_r, amount: amount_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == CMD_WR_NEW)   count_r <= count_r + 1'b1;
      if (cmd.op == CMD_DEL_DONE) count_r <= count_r - 1'b1;
      if (cmd.result)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    case (cmd.op)
      CMD_LOAD: begin
        op_r     <= in_opcode;
        key_r    <= in_key;
        price_r  <= in_price;
        amount_r <= in_amount;
        rank_r   <= in_rank;
      end
      CMD_SRCH_INIT: begin
        lo_r <= '0;
        hi_r <= count_r;
      end
      CMD_RD_MID: mid_r <= mid_w;
      CMD_CMP_MID: begin
        if (rdata_r.key < key_r) lo_r <= mid_r + 1'b1;
        else                     hi_r <= mid_r;
      end
      CMD_INS_INIT: idx_r <= count_r;
      CMD_INS_WR:   idx_r <= idx_r - 1'b1;
      CMD_DEL_INIT: idx_r <= lo_r;
      CMD_DEL_WR:   idx_r <= idx_r + 1'b1;
      default: ;
    endcase
    if (cmd.result) begin
      out_status_r <= cmd.code;
      out_entry_r  <= (cmd.code == ST_READOK) ? rdata_r : '0;
      out_count_r  <= 11'(count_r);
    end
  end

  always_comb begin
    sts.opcode    = op_r;
    sts.amt_pos   = (amount_r != '0) && !amount_r[31];
    sts.rank_ok   = 32'(rank_r) < 32'(count_r);
    sts.srch_done = (lo_r == hi_r);
    sts.hit       = (lo_r < count_r) && (rdata_r.key == key_r);
    sts.full      = (32'(count_r) == TABLE_DEPTH);
    sts.ins_done  = (idx_r == lo_r);
    sts.del_done  = ({1'b0, idx_r} + 1'b1) >= {1'b0, count_r};
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_entry  = out_entry_r;
  assign out_count  = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= TABLE_DEPTH) else $error("entry count above table depth");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken beat");
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |=> out_valid_r) else $error("result beat not presented");
  a_del_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == CMD_DEL_DONE) |-> (count_r != '0))
    else $error("delete from empty table");

endmodule

// ----- hw/rtl/order_book_level_table.sv -----
// ----------------------------------------------------------------------------
// order_book_level_table
// Sorted table of price levels with insert, modify, delete and read by rank.
// ----------------------------------------------------------------------------
// One command beat enters on the in_ channel and exactly one result beat
// leaves on the out_ channel. The table is held in one entry memory with a
// single registered read port, kept in ascending key order.
// Insert and modify run a binary search (a memory read, then a compare, per
// probe), a hit check, and for a new key a shift of every entry above the
// slot, one read and one write per entry. Delete shifts the entries above
// the removed one the same way. A read by rank and a rejected command skip
// the search. The memory port does at most one read or one write per
// cycle.
// Commands are taken one at a time; in_tready is high only while idle. A
// result waits in the output register while the receiver stalls, and the
// next command is accepted meanwhile; its result waits until that beat is
// taken. Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module order_book_level_table import obl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // level_key[15:0], price_cents[47:16], amount[79:48], rank[89:80]
  input  logic [95:0] in_tdata,
  // opcode[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_key[15:0], out_price[47:16], out_amount[79:48], entry_count[90:80]
  output logic [95:0] out_tdata,
  // status[3:0]
  output logic [3:0]  out_tuser
);

  obl_cmd_t    cmd;
  obl_sts_t    sts;
  status_t     res_status;
  entry_t      res_entry;
  logic [10:0] res_count;

  obl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  obl_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_opcode  (in_tuser),
    .in_key     (in_tdata[15:0]),
    .in_price   (in_tdata[47:16]),
    .in_amount  (in_tdata[79:48]),
    .in_rank    (in_tdata[89:80]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .out_entry  (res_entry),
    .out_count  (res_count)
  );

  assign out_tuser = res_status;
  assign out_tdata = {5'd0, res_count, res_entry.amount, res_entry.price, res_entry.key};

endmodule

// ----- tb/tb_order_book_level_table.sv -----
// ----------------------------------------------------------------------------
// tb_order_book_level_table
// Self-checking testbench of the sorted price level table.
// ----------------------------------------------------------------------------
// Commands are queued by a stimulus process and sent by a clocked driver with
// random gaps. A clocked monitor takes result beats with random stalls and
// compares each one with the oldest prediction of a behavioral table model.
// The directed part covers each opcode, field extremes, ignored amounts,
// absent keys, rank overflow and a completely full table.
// ----------------------------------------------------------------------------
module tb_order_book_level_table;
  import obl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] key;
    logic [31:0] price;
    logic [31:0] amount;
    logic [9:0]  rank;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] key;
    logic [31:0] price;
    logic [31:0] amount;
    logic [10:0] count;
  } rsp_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic [3:0]  out_tuser;

  cmd_t        pending_cmds[$];
  rsp_t        expected_rsps[$];
  logic [15:0] book_key[TABLE_DEPTH];
  logic [31:0] book_price[TABLE_DEPTH];
  logic [31:0] book_amount[TABLE_DEPTH];
  int          book_used;
  int          errors;
  int          stim_done;
  int          hold_cycles;
  int          send_gap;
  int          recv_gap;
  longint      cycle_count;

  order_book_level_table i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic rsp_t apply_to_book(cmd_t c);
    rsp_t r;
    int   slot;
    bit   hit;
    r = '0;
    slot = 0;
    while (slot < book_used && book_key[slot] < c.key) slot++;
    hit = slot < book_used && book_key[slot] == c.key;
    if (c.opcode == OP_INSERT || c.opcode == OP_MODIFY) begin
      if ($signed(c.amount) <= 0) begin
        r.status = ST_IGNORED;
      end else if (hit) begin
        book_price[slot] = c.price;
        book_amount[slot] = c.amount;
        r.status = ST_MODIFIED;
      end else if (book_used >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (int i = book_used; i > slot; i--) begin
          book_key[i] = book_key[i-1];
          book_price[i] = book_price[i-1];
          book_amount[i] = book_amount[i-1];
        end
        book_key[slot] = c.key;
        book_price[slot] = c.price;
        book_amount[slot] = c.amount;
        book_used++;
        r.status = ST_INSERTED;
      end
    end else if (c.opcode == OP_DELETE) begin
      if (hit) begin
        for (int i = slot; i < book_used - 1; i++) begin
          book_key[i] = book_key[i+1];
          book_price[i] = book_price[i+1];
          book_amount[i] = book_amount[i+1];
        end
        book_used--;
        r.status = ST_DELETED;
      end else begin
        r.status = ST_NOTFOUND;
      end
    end else if (c.opcode == OP_READ) begin
      if (c.rank < book_used) begin
        r.key = book_key[c.rank];
        r.price = book_price[c.rank];
        r.amount = book_amount[c.rank];
        r.status = ST_READOK;
      end else begin
        r.status = ST_RANKOUT;
      end
    end else begin
      r.status = ST_UNKNOWN;
    end
    r.count = book_used[10:0];
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] op, logic [15:0] k, logic [31:0] p,
                                    logic [31:0] a, logic [9:0] rk);
    cmd_t c;
    c.opcode = op;
    c.key = k;
    c.price = p;
    c.amount = a;
    c.rank = rk;
    return c;
  endfunction

  function automatic logic [31:0] rand_amount();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return $urandom | 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return $urandom_range(1, 32'h7fff_ffff);
    endcase
  endfunction

  // Keys come from a narrow pool most of the time so that hits are common.
  function automatic logic [15:0] rand_key();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'(1000 + $urandom_range(0, 63));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
      send_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap > 0 || pending_cmds.size() == 0) begin
        in_tvalid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        cmd_t c;
        c = pending_cmds.pop_front();
        expected_rsps.push_back(apply_to_book(c));
        in_tvalid <= 1'b1;
        in_tuser <= c.opcode;
        in_tdata <= {6'b0, c.rank, c.amount, c.price, c.key};
        send_gap <= (stim_done && $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        rsp_t want;
        rsp_t got;
        got = {out_tuser, out_tdata[15:0], out_tdata[47:16], out_tdata[79:48],
               out_tdata[90:80]};
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result beat status=%0d data=%h", $time, out_tuser,
                   out_tdata);
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.key !== want.key) begin
            $display("%0t: out_key expected %h actual %h", $time, want.key, got.key);
            errors++;
          end
          if (got.price !== want.price) begin
            $display("%0t: out_price expected %h actual %h", $time, want.price, got.price);
            errors++;
          end
          if (got.amount !== want.amount) begin
            $display("%0t: out_amount expected %h actual %h", $time, want.amount,
                     got.amount);
            errors++;
          end
          if (got.count !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                     got.count);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        out_tready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if (out_tvalid && out_tready) begin
        recv_gap <= $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 12_000_000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int k;
    errors = 0;
    stim_done = 0;
    cycle_count = 0;
    hold_cycles = 0;
    book_used = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    pending_cmds.push_back(make_cmd(OP_READ, 16'h0, 32'h0, 32'h0, 10'd0));
    pending_cmds.push_back(make_cmd(OP_DELETE, 16'h1234, 32'h0, 32'h0, 10'd0));
    pending_cmds.push_back(make_cmd(OP_INSERT, 16'hffff, 32'h7fff_ffff, 32'h7fff_ffff, 10'd0));
    pending_cmds.push_back(make_cmd(OP_MODIFY, 16'h0000, 32'h8000_0000, 32'd1, 10'd0));
    pending_cmds.push_back(make_cmd(OP_INSERT, 16'h8000, 32'hffff_ffff, 32'd0, 10'd0));
    pending_cmds.push_back(make_cmd(OP_MODIFY, 16'h8000, 32'd5, 32'h8000_0000, 10'd0));
    pending_cmds.push_back(make_cmd(OP_INSERT, 16'h0000, 32'd77, 32'd9, 10'd0));
    pending_cmds.push_back(make_cmd(OP_MODIFY, 16'h4000, 32'd12, 32'd3, 10'd0));
    pending_cmds.push_back(make_cmd(3'd4, 16'h1, 32'h1, 32'h1, 10'd1));
    pending_cmds.push_back(make_cmd(3'd5, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 10'h3ff));
    pending_cmds.push_back(make_cmd(3'd6, 16'h0, 32'h0, 32'h0, 10'd0));
    pending_cmds.push_back(make_cmd(3'd7, 16'h5555, 32'haaaa_aaaa, 32'h5555_5555, 10'h2aa));
    for (int i = 0; i < 4; i++) pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 10'(i)));
    pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 10'h3ff));
    pending_cmds.push_back(make_cmd(OP_DELETE, 16'h4000, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DELETE, 16'hffff, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DELETE, 16'hffff, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DELETE, 16'h0000, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DELETE, 16'h4000, 0, 0, 0));
    while (pending_cmds.size() > 0) @(posedge clk);

    // Fill the table completely, reverse key order to force full shifts.
    for (int i = 0; i < TABLE_DEPTH; i++)
      pending_cmds.push_back(make_cmd(OP_INSERT, 16'(2 * (TABLE_DEPTH - i)), $urandom,
                                      $urandom_range(1, 1000), 0));
    pending_cmds.push_back(make_cmd(OP_INSERT, 16'd1, 32'd1, 32'd1, 0));
    pending_cmds.push_back(make_cmd(OP_MODIFY, 16'd4, 32'd2, 32'd2, 0));
    pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 10'h3ff));
    pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 10'd0));
    while (pending_cmds.size() > 0) @(posedge clk);
    for (int i = 0; i < TABLE_DEPTH; i++)
      pending_cmds.push_back(make_cmd(OP_DELETE, 16'(2 * (i + 1)), 0, 0, 0));

    // The receiver holds off while the sender keeps offering commands.
    hold_cycles = 400;
    for (int i = 0; i < 750; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45)
        pending_cmds.push_back(make_cmd(3'($urandom_range(0, 1)), rand_key(), $urandom,
                                        rand_amount(), 10'($urandom)));
      else if (k < 65)
        pending_cmds.push_back(make_cmd(OP_DELETE, rand_key(), $urandom, $urandom,
                                        10'($urandom)));
      else if (k < 92)
        pending_cmds.push_back(make_cmd(OP_READ, 16'($urandom), $urandom, $urandom,
                                        ($urandom_range(0, 7) == 0) ? 10'($urandom)
                                        : 10'($urandom_range(0, 80))));
      else
        pending_cmds.push_back(make_cmd(3'($urandom_range(4, 7)), 16'($urandom), $urandom,
                                        $urandom, 10'($urandom)));
    end
    stim_done = 1;
    while (pending_cmds.size() > 0 || in_tvalid || expected_rsps.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- order_book_level_table.f -----
hw/rtl/obl_pkg.sv
hw/rtl/obl_ctrl.sv
hw/rtl/obl_dp.sv
hw/rtl/order_book_level_table.sv
tb/tb_order_book_level_table.sv
